### rtl/core/oale_pkg.sv
// ----------------------------------------------------------------------------
// Ordered array list engine package
// Shared constants, mode and status codes, and transaction payload types.
// ----------------------------------------------------------------------------
package oale_pkg;

   localparam int CAPACITY_DEF   = 64;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int MODE_WIDTH     = 3;
   localparam int POS_WIDTH      = 7;
   localparam int VALUE_WIDTH    = 32;
   localparam int STATUS_WIDTH   = 3;
   localparam int FOUND_WIDTH    = 6;
   localparam int COUNT_WIDTH    = 7;

   localparam logic [MODE_WIDTH-1:0] MODE_GET    = 3'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_LOCATE = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_INSERT = 3'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_DELETE = 3'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_PURGE  = 3'd4;

   localparam logic [STATUS_WIDTH-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_BADPOS   = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY    = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] ST_NOTFOUND = 3'd4;

   typedef struct packed {
      logic [MODE_WIDTH-1:0]  mode;
      logic [POS_WIDTH-1:0]   position;
      logic [VALUE_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic [VALUE_WIDTH-1:0]  read_value;
      logic [FOUND_WIDTH-1:0]  found_index;
      logic [COUNT_WIDTH-1:0]  entry_count;
   } rsp_type;

endpackage

### rtl/core/oale_ram.sv
// ----------------------------------------------------------------------------
// Ordered array list engine RAM
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module oale_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/ordered_array_list_engine.sv
// ----------------------------------------------------------------------------
// Ordered array list engine
// Ordered list of up to CAPACITY values: get, locate, insert, delete, purge.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction (req_valid/req_ready, req_data) carries a mode, a
//   position and a value. Each request gives exactly one response transaction
//   (rsp_valid/rsp_ready, rsp_data) with status, read value, found index and
//   the entry count after the operation.
//   One request is worked on at a time; req_ready is high only while the
//   sequencer is idle. All list access goes through one RAM with one write
//   and one registered read port, so each operation walks the list entry by
//   entry: locate reads until a match, insert moves the entries from the end
//   down to the position up by one, delete moves those after the position
//   down by one, purge checks each entry against the entries kept before it.
//   Rejected or unused modes go straight to the response. The sequencer
//   returns to idle as the response register loads.
//   The response register frees the request side: a new request is taken
//   while a response waits; its own response is held inside until the
//   receiver takes the waiting one.
//   Reset empties the list (count zero) and drops any pending response; the
//   RAM contents are not cleared and are only read after being written.
// ----------------------------------------------------------------------------
module ordered_array_list_engine
   import oale_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int DW = DATA_WIDTH;
   localparam int XW = (CW > POS_WIDTH) ? CW : POS_WIDTH;
   localparam int VW = (DW > VALUE_WIDTH) ? DW : VALUE_WIDTH;
   localparam int FW = (CW > FOUND_WIDTH) ? CW : FOUND_WIDTH;
   localparam int EW = (CW > COUNT_WIDTH) ? CW : COUNT_WIDTH;
   localparam logic [CW-1:0] CAP_CW = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_CW = CW'(1);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DISPATCH  = 4'd1;
   localparam logic [3:0] S_GET_DATA  = 4'd2;
   localparam logic [3:0] S_LOC_SCAN  = 4'd3;
   localparam logic [3:0] S_INS_SHIFT = 4'd4;
   localparam logic [3:0] S_DEL_SHIFT = 4'd5;
   localparam logic [3:0] S_PUR_CAND  = 4'd6;
   localparam logic [3:0] S_PUR_SCAN  = 4'd7;
   localparam logic [3:0] S_PUR_NEXT  = 4'd8;
   localparam logic [3:0] S_FINISH    = 4'd9;

   logic [3:0]              state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    pend_ff, pend_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;
   logic [MODE_WIDTH-1:0]   mode_ff, mode_in;
   logic [XW-1:0]           pos_ff, pos_in;
   logic [DW-1:0]           val_ff, val_in;
   logic [DW-1:0]           cand_ff, cand_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic [CW-1:0]           wptr_ff, wptr_in;
   logic [CW-1:0]           kidx_ff, kidx_in;
   logic [CW-1:0]           paddr_ff, paddr_in;
   logic [STATUS_WIDTH-1:0] res_status_ff, res_status_in;
   logic [VALUE_WIDTH-1:0]  res_read_ff, res_read_in;
   logic [FOUND_WIDTH-1:0]  res_found_ff, res_found_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [DW-1:0] ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [DW-1:0] ram_rdata;

   logic [XW-1:0] count_x;
   logic [CW-1:0] pos_cw;
   logic [CW-1:0] pos_inc;
   logic [CW-1:0] idx_inc;
   logic [CW-1:0] idx_dec;
   logic [CW-1:0] paddr_inc;
   logic [CW-1:0] paddr_dec;
   logic [VW-1:0] val_wide;
   logic [VW-1:0] rd_wide;
   logic [FW-1:0] found_wide;
   logic [EW-1:0] count_wide;

   oale_ram #(
      .WIDTH (DW),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign count_x    = XW'(count_ff);
   assign pos_cw     = pos_ff[CW-1:0];
   assign pos_inc    = pos_cw + 1'b1;
   assign idx_inc    = idx_ff + 1'b1;
   assign idx_dec    = idx_ff - 1'b1;
   assign paddr_inc  = paddr_ff + 1'b1;
   assign paddr_dec  = paddr_ff - 1'b1;
   assign val_wide   = VW'(req_data.value);
   assign rd_wide    = VW'(ram_rdata);
   assign found_wide = FW'(paddr_ff);
   assign count_wide = EW'(count_ff);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pend_in       = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      mode_in       = mode_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      cand_in       = cand_ff;
      idx_in        = idx_ff;
      wptr_in       = wptr_ff;
      kidx_in       = kidx_ff;
      paddr_in      = paddr_ff;
      res_status_in = res_status_ff;
      res_read_in   = res_read_ff;
      res_found_in  = res_found_ff;
      ram_we        = 1'b0;
      ram_waddr     = paddr_inc[AW-1:0];
      ram_wdata     = ram_rdata;
      ram_raddr     = idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in  = req_data.mode;
               pos_in   = XW'(req_data.position);
               val_in   = val_wide[DW-1:0];
               state_in = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            res_status_in = ST_OK;
            res_read_in   = '0;
            res_found_in  = '0;
            state_in      = S_FINISH;
            case (mode_ff)
               MODE_GET: begin
                  if (pos_ff >= count_x) begin
                     res_status_in = ST_BADPOS;
                  end else begin
                     ram_raddr = pos_cw[AW-1:0];
                     state_in  = S_GET_DATA;
                  end
               end
               MODE_LOCATE: begin
                  res_status_in = ST_NOTFOUND;
                  idx_in        = '0;
                  state_in      = S_LOC_SCAN;
               end
               MODE_INSERT: begin
                  if (count_ff >= CAP_CW) begin
                     res_status_in = ST_FULL;
                  end else if (pos_ff > count_x) begin
                     res_status_in = ST_BADPOS;
                  end else begin
                     idx_in   = count_ff;
                     state_in = S_INS_SHIFT;
                  end
               end
               MODE_DELETE: begin
                  if (count_ff == '0) begin
                     res_status_in = ST_EMPTY;
                  end else if (pos_ff >= count_x) begin
                     res_status_in = ST_BADPOS;
                  end else begin
                     idx_in   = pos_inc;
                     state_in = S_DEL_SHIFT;
                  end
               end
               MODE_PURGE: begin
                  if (count_ff > ONE_CW) begin
                     ram_raddr = ONE_CW[AW-1:0];
                     idx_in    = ONE_CW;
                     wptr_in   = ONE_CW;
                     state_in  = S_PUR_CAND;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end

         S_GET_DATA: begin
            res_read_in = rd_wide[VALUE_WIDTH-1:0];
            state_in    = S_FINISH;
         end

         S_LOC_SCAN: begin
            if (pend_ff && (ram_rdata == val_ff)) begin
               res_status_in = ST_OK;
               res_found_in  = found_wide[FOUND_WIDTH-1:0];
               state_in      = S_FINISH;
            end else if (idx_ff < count_ff) begin
               ram_raddr = idx_ff[AW-1:0];
               pend_in   = 1'b1;
               paddr_in  = idx_ff;
               idx_in    = idx_inc;
            end else if (!pend_ff) begin
               state_in = S_FINISH;
            end
         end

         S_INS_SHIFT: begin
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = paddr_inc[AW-1:0];
               ram_wdata = ram_rdata;
            end
            if (idx_ff > pos_cw) begin
               ram_raddr = idx_dec[AW-1:0];
               pend_in   = 1'b1;
               paddr_in  = idx_dec;
               idx_in    = idx_dec;
            end else if (!pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = pos_cw[AW-1:0];
               ram_wdata = val_ff;
               count_in  = count_ff + 1'b1;
               state_in  = S_FINISH;
            end
         end

         S_DEL_SHIFT: begin
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = paddr_dec[AW-1:0];
               ram_wdata = ram_rdata;
            end
            if (idx_ff < count_ff) begin
               ram_raddr = idx_ff[AW-1:0];
               pend_in   = 1'b1;
               paddr_in  = idx_ff;
               idx_in    = idx_inc;
            end else if (!pend_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_FINISH;
            end
         end

         S_PUR_CAND: begin
            cand_in  = ram_rdata;
            kidx_in  = '0;
            state_in = S_PUR_SCAN;
         end

         S_PUR_SCAN: begin
            if (pend_ff && (ram_rdata == cand_ff)) begin
               idx_in   = idx_inc;
               state_in = S_PUR_NEXT;
            end else if (kidx_ff < wptr_ff) begin
               ram_raddr = kidx_ff[AW-1:0];
               pend_in   = 1'b1;
               kidx_in   = kidx_ff + 1'b1;
            end else if (!pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = wptr_ff[AW-1:0];
               ram_wdata = cand_ff;
               wptr_in   = wptr_ff + 1'b1;
               idx_in    = idx_inc;
               state_in  = S_PUR_NEXT;
            end
         end

         S_PUR_NEXT: begin
            if (idx_ff == count_ff) begin
               count_in = wptr_ff;
               state_in = S_FINISH;
            end else begin
               ram_raddr = idx_ff[AW-1:0];
               state_in  = S_PUR_CAND;
            end
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = res_status_ff;
               rsp_data_in.read_value  = res_read_ff;
               rsp_data_in.found_index = res_found_ff;
               rsp_data_in.entry_count = count_wide[COUNT_WIDTH-1:0];
               state_in                = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      mode_ff       <= mode_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      cand_ff       <= cand_in;
      idx_ff        <= idx_in;
      wptr_ff       <= wptr_in;
      kidx_ff       <= kidx_in;
      paddr_ff      <= paddr_in;
      res_status_ff <= res_status_in;
      res_read_ff   <= res_read_in;
      res_found_ff  <= res_found_in;
   end

endmodule

### bench/ordered_array_list_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array list engine testbench
// Drives get, locate, insert, delete, purge and unused-mode requests, with
// directed corner cases first and then fill and drain sweeps with random
// content. It predicts every response from a shadow copy of the list and
// checks it field by field. Pacing runs through phases of sender gaps and
// receiver stalls, with one long receiver hold that backs the engine up.
// ----------------------------------------------------------------------------
module ordered_array_list_engine_tb;
   import oale_pkg::*;

   localparam int LIST_CAP     = CAPACITY_DEF;
   localparam int STIM_ITEMS   = 1525;
   localparam int IDLE_LIMIT   = 20000;
   localparam int HOLD_CYCLES  = 600;
   localparam int HOLD_AT      = 200;
   localparam int PLAN_SIDE    = 0;
   localparam int CHECK_SIDE   = 1;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // two shadow lists: one steers stimulus, one predicts responses
   logic [VALUE_WIDTH-1:0] list_mem [0:1][0:LIST_CAP-1];
   int                     list_len [0:1];

   req_type pending_items[$];
   rsp_type predicted_replies[$];

   int stim_total = 0;
   int req_taken = 0;
   int rsp_taken = 0;
   int mismatches = 0;
   int idle_cycles = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int status_seen [0:7];

   ordered_array_list_engine uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   function automatic void list_drop(input int side, input int pos);
      int j;
      for (j = pos; j < list_len[side] - 1; j++) begin
         list_mem[side][j] = list_mem[side][j + 1];
      end
      list_len[side]--;
   endfunction

   function automatic rsp_type list_apply(input int side, input req_type r);
      rsp_type res;
      int      j;
      int      k;
      bit      seen;
      res = '0;
      case (r.mode)
         MODE_GET: begin
            if (r.position >= list_len[side]) begin
               res.status = ST_BADPOS;
            end else begin
               res.read_value = list_mem[side][r.position];
            end
         end
         MODE_LOCATE: begin
            res.status = ST_NOTFOUND;
            for (j = 0; j < list_len[side] && res.status != ST_OK; j++) begin
               if (list_mem[side][j] == r.value) begin
                  res.status = ST_OK;
                  res.found_index = FOUND_WIDTH'(j);
               end
            end
         end
         MODE_INSERT: begin
            if (list_len[side] >= LIST_CAP) begin
               res.status = ST_FULL;
            end else if (r.position > list_len[side]) begin
               res.status = ST_BADPOS;
            end else begin
               for (j = list_len[side]; j > r.position; j--) begin
                  list_mem[side][j] = list_mem[side][j - 1];
               end
               list_mem[side][r.position] = r.value;
               list_len[side]++;
            end
         end
         MODE_DELETE: begin
            if (list_len[side] == 0) begin
               res.status = ST_EMPTY;
            end else if (r.position >= list_len[side]) begin
               res.status = ST_BADPOS;
            end else begin
               list_drop(side, r.position);
            end
         end
         MODE_PURGE: begin
            j = 1;
            while (j < list_len[side]) begin
               seen = 1'b0;
               for (k = 0; k < j; k++) begin
                  if (list_mem[side][k] == list_mem[side][j]) seen = 1'b1;
               end
               if (seen) begin
                  list_drop(side, j);
               end else begin
                  j++;
               end
            end
         end
         default: begin
         end
      endcase
      res.entry_count = COUNT_WIDTH'(list_len[side]);
      return res;
   endfunction

   function automatic void plan_item(input logic [MODE_WIDTH-1:0] mode, input int pos,
                                     input logic [VALUE_WIDTH-1:0] val);
      req_type r;
      r.mode = mode;
      r.position = POS_WIDTH'(pos);
      r.value = val;
      void'(list_apply(PLAN_SIDE, r));
      pending_items.push_back(r);
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 30) return VALUE_WIDTH'($urandom_range(0, 15));
      if (roll < 35) return '1;
      if (roll < 40) return '0;
      return $urandom;
   endfunction

   function automatic int pick_position();
      if ($urandom_range(0, 99) < 85) return $urandom_range(0, list_len[PLAN_SIDE]);
      return $urandom_range(0, 127);
   endfunction

   function automatic int pace_phase();
      int p;
      p = (stim_total == 0) ? 0 : (req_taken * 4) / stim_total;
      return (p > 3) ? 3 : p;
   endfunction

   function automatic int gap_pct();
      case (pace_phase())
         1: return 65;
         3: return 13;
         default: return 0;
      endcase
   endfunction

   function automatic int stall_pct();
      case (pace_phase())
         2: return 65;
         3: return 13;
         default: return 0;
      endcase
   endfunction

   task automatic plan_fill_burst();
      while (list_len[PLAN_SIDE] < LIST_CAP) begin
         plan_item(MODE_INSERT, $urandom_range(0, list_len[PLAN_SIDE]), pick_value());
      end
      plan_item(MODE_INSERT, $urandom_range(0, 127), pick_value());
      plan_item(MODE_INSERT, 0, pick_value());
   endtask

   task automatic plan_stimulus();
      int roll;
      int len;
      int next_burst;
      bit filling;
      list_len[PLAN_SIDE] = 0;

      plan_item(MODE_GET, 0, '0);
      plan_item(MODE_LOCATE, 0, '0);
      plan_item(MODE_DELETE, 0, '0);
      plan_item(MODE_PURGE, 0, '0);
      plan_item(MODE_INSERT, 1, 32'h0000_0001);
      plan_item(MODE_INSERT, 0, 32'hFFFF_FFFF);
      plan_item(MODE_INSERT, 1, 32'h0000_0000);
      plan_item(MODE_INSERT, 0, 32'h0000_0005);
      plan_item(MODE_INSERT, 1, 32'hFFFF_FFFF);
      plan_item(MODE_INSERT, 4, 32'h0000_0005);
      plan_item(MODE_GET, 3, '0);
      plan_item(MODE_GET, 4, '0);
      plan_item(MODE_GET, 127, '1);
      plan_item(MODE_LOCATE, 0, 32'hFFFF_FFFF);
      plan_item(MODE_LOCATE, 0, 32'h0000_1234);
      plan_item(MODE_DELETE, 127, '0);
      plan_item(MODE_DELETE, 4, '0);
      plan_item(MODE_INSERT, 4, 32'h0000_0005);
      plan_item(MODE_PURGE, 0, '0);
      plan_item(MODE_PURGE + 3'd1, 127, '1);
      plan_item(MODE_PURGE + 3'd2, 127, '1);
      plan_item(MODE_PURGE + 3'd3, 127, '1);
      plan_item(MODE_DELETE, 0, '0);
      plan_item(MODE_INSERT, 127, '1);
      plan_item(MODE_LOCATE, 0, '0);

      filling = 1'b1;
      next_burst = pending_items.size();
      while (pending_items.size() < STIM_ITEMS) begin
         if (pending_items.size() >= next_burst) begin
            plan_fill_burst();
            filling = 1'b0;
            next_burst += STIM_ITEMS / 4;
         end
         len = list_len[PLAN_SIDE];
         if (len == LIST_CAP && $urandom_range(0, 3) == 0) filling = 1'b0;
         if (len == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
         if ($urandom_range(0, 99) == 0) filling = !filling;
         roll = $urandom_range(0, 99);
         if (roll < (filling ? 55 : 10)) begin
            plan_item(MODE_INSERT, pick_position(), pick_value());
         end else if (roll < 65) begin
            plan_item(MODE_DELETE, pick_position(), pick_value());
         end else if (roll < 78) begin
            plan_item(MODE_GET, pick_position(), pick_value());
         end else if (roll < 91) begin
            if (len > 0 && $urandom_range(0, 99) < 60) begin
               plan_item(MODE_LOCATE, pick_position(),
                         list_mem[PLAN_SIDE][$urandom_range(0, len - 1)]);
            end else begin
               plan_item(MODE_LOCATE, pick_position(), pick_value());
            end
         end else if (roll < 95) begin
            plan_item(MODE_PURGE, pick_position(), pick_value());
         end else begin
            plan_item(MODE_PURGE + 3'($urandom_range(1, 3)), pick_position(), pick_value());
         end
      end
      stim_total = pending_items.size();
   endtask

   function automatic void report_mismatch(input string what, input rsp_type exp,
                                           input rsp_type got);
      if (mismatches < 10) begin
         $display("[%0t] %s: expected status %0d value %h index %0d count %0d, got status %0d value %h index %0d count %0d",
                  $realtime, what, exp.status, exp.read_value, exp.found_index,
                  exp.entry_count, got.status, got.read_value, got.found_index,
                  got.entry_count);
      end
      mismatches++;
   endfunction

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin : request_driver
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_replies.push_back(list_apply(CHECK_SIDE, req_data));
            req_taken <= req_taken + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= gap_pct()) begin
               req_data <= pending_items.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : response_monitor
      rsp_type exp;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_taken <= rsp_taken + 1;
            status_seen[rsp_data.status]++;
            if (predicted_replies.size() == 0) begin
               report_mismatch("unexpected response", '0, rsp_data);
            end else begin
               exp = predicted_replies.pop_front();
               if (rsp_data.status !== exp.status ||
                   rsp_data.read_value !== exp.read_value ||
                   rsp_data.found_index !== exp.found_index ||
                   rsp_data.entry_count !== exp.entry_count) begin
                  report_mismatch("response mismatch", exp, rsp_data);
               end
            end
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (!hold_done && req_taken >= HOLD_AT) begin
            // hold off long enough for the engine to back up into the request side
            rsp_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct());
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : sequencer
      int s;
      for (s = 0; s < 8; s++) status_seen[s] = 0;
      list_len[CHECK_SIDE] = 0;
      plan_stimulus();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (req_taken < stim_total) @(posedge clock);
      while (predicted_replies.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Ran %0d requests (%0d responses) through unpaced, gapped, stalled and mixed phases plus one long response hold.",
               req_taken, rsp_taken);
      $display("Status mix: ok %0d, full %0d, bad position %0d, empty %0d, not found %0d; mismatches %0d",
               status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BADPOS],
               status_seen[ST_EMPTY], status_seen[ST_NOTFOUND], mismatches);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
